[rtl/frm_pkg.sv]
package frm_pkg;

  localparam int MAX_FRAME_DEF = 1024;
  localparam int SAMPLE_W      = 16;
  localparam int RMS_W         = 15;
  localparam int COUNT_W       = 11;
  localparam int SQUARE_W      = 2 * SAMPLE_W;
  localparam int RMS_MAX       = 32767;
  localparam int COUNT_OUT_MAX = 2047;

  // One command per datapath operation; at most one is active in a cycle.
  typedef struct packed {
    logic acc;       // accumulate the sample being transferred
    logic div_load;  // latch frame totals into the divider, clear accumulator
    logic div_step;  // one quotient bit
    logic sq_load;   // move quotient into the root unit
    logic sq_step;   // one root bit
    logic out_load;  // capture result into the output register
  } frm_cmd_t;

endpackage

[rtl/frm_ctrl.sv]
module frm_ctrl #(
  parameter int SUM_W  = 41,
  parameter int ROOT_W = 21
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output frm_pkg::frm_cmd_t cmd
);
  import frm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    S_ACC,
    S_LOAD,
    S_DIV,
    S_SQLOAD,
    S_SQRT,
    S_FIN
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;

  always_comb begin
    cmd          = '0;
    cmd.acc      = (state == S_ACC) && in_valid;
    cmd.div_load = (state == S_LOAD);
    cmd.div_step = (state == S_DIV);
    cmd.sq_load  = (state == S_SQLOAD);
    cmd.sq_step  = (state == S_SQRT);
    cmd.out_load = (state == S_FIN) && (!out_valid || out_ready);
  end

  assign in_ready = (state == S_ACC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ACC: begin
          if (in_valid && last) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == STEP_W'(SUM_W - 1)) begin
            step  <= '0;
            state <= S_SQLOAD;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SQLOAD: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (step == STEP_W'(ROOT_W - 1)) begin
            step  <= '0;
            state <= S_FIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_FIN: begin
          if (cmd.out_load) begin
            state <= S_ACC;
          end
        end
        default: begin
          state <= S_ACC;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.acc, cmd.div_load, cmd.div_step, cmd.sq_load, cmd.sq_step, cmd.out_load}))
    else $error("more than one datapath command active");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last) |=> (state == S_LOAD && !in_ready))
    else $error("last sample did not start evaluation");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> (step < STEP_W'(ROOT_W)))
    else $error("root step counter out of range");
`endif

endmodule

[rtl/frm_dp.sv]
module frm_dp #(
  parameter int MAX_FRAME = 1024,
  parameter int CNT_W     = 11,
  parameter int SUM_W     = 41,
  parameter int ROOT_W    = 21
) (
  input  logic                               clk,
  input  logic                               rst,
  input  frm_pkg::frm_cmd_t                  cmd,
  input  logic signed [frm_pkg::SAMPLE_W-1:0] sample,
  output logic [frm_pkg::RMS_W-1:0]          rms,
  output logic [frm_pkg::COUNT_W-1:0]        sample_count,
  output logic                               overflow
);
  import frm_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int EXT_W = CNT_W + COUNT_W;

  // accumulator
  logic [SUM_W-1:0]    square_sum;
  logic [CNT_W-1:0]    frame_count;
  logic                too_long;
  logic [SAMPLE_W-1:0] mag;
  logic [SQUARE_W-1:0] square;

  // divider
  logic [SUM_W-1:0] quo;
  logic [CNT_W-1:0] drem;
  logic [CNT_W-1:0] divisor;
  logic             flag_hold;
  logic [CNT_W:0]   dshift;
  logic [CNT_W:0]   ddiff;
  logic             dfit;

  // root
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  srem;
  logic [REM_W+1:0]  sshift;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  sdiff;
  logic              sfit;

  logic [EXT_W-1:0]   cnt_ext;
  logic [RMS_W-1:0]   rms_next;
  logic [COUNT_W-1:0] count_next;

  assign mag    = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  assign square = SQUARE_W'(mag) * SQUARE_W'(mag);

  assign dshift = {drem, quo[SUM_W-1]};
  assign ddiff  = dshift - {1'b0, divisor};
  assign dfit   = (dshift >= {1'b0, divisor});

  assign sshift = {srem, rad[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root, 2'b01});
  assign sdiff  = sshift - trial;
  assign sfit   = (sshift >= trial);

  assign rms_next = (root > ROOT_W'(RMS_MAX)) ? RMS_W'(RMS_MAX) : root[RMS_W-1:0];
  assign cnt_ext  = EXT_W'(divisor);
  assign count_next = (cnt_ext > EXT_W'(COUNT_OUT_MAX)) ? COUNT_W'(COUNT_OUT_MAX)
                                                        : cnt_ext[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum  <= '0;
      frame_count <= '0;
      too_long    <= 1'b0;
    end else if (cmd.acc) begin
      if (frame_count < CNT_W'(MAX_FRAME)) begin
        square_sum  <= square_sum + SUM_W'(square);
        frame_count <= frame_count + 1'b1;
      end else begin
        too_long <= 1'b1;
      end
    end else if (cmd.div_load) begin
      square_sum  <= '0;
      frame_count <= '0;
      too_long    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo       <= square_sum;
      drem      <= '0;
      divisor   <= frame_count;
      flag_hold <= too_long;
    end else if (cmd.div_step) begin
      quo  <= {quo[SUM_W-2:0], dfit};
      drem <= dfit ? ddiff[CNT_W-1:0] : dshift[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      rad  <= RAD_W'(quo);
      root <= '0;
      srem <= '0;
    end else if (cmd.sq_step) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      root <= {root[ROOT_W-2:0], sfit};
      srem <= sfit ? sdiff[REM_W-1:0] : sshift[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rms          <= rms_next;
      sample_count <= count_next;
      overflow     <= flag_hold;
    end
  end

endmodule

[rtl/frame_rms_meter_top.sv]
// Frame RMS meter. Signed Q4.12 samples are transferred one per cycle and
// their squares summed (Q8.24) until the sample flagged last; then the
// block stops taking samples, divides the sum by the sample count with a
// restoring divider (one quotient bit per cycle, SUM_W quotient bits, 41 at the
// default MAX_FRAME of 1024) and takes the floor square root with a
// digit-recurrence unit (one root bit per cycle, ROOT_W root bits, 21 by
// default). The next frame's first sample is taken only once the result
// has gone into the output register; a result still waiting in the
// output register holds the block only when the next frame is ready to
// deliver. rms saturates at 32767, sample_count at 2047, and samples
// beyond MAX_FRAME are dropped with overflow set on that frame's result.
module frame_rms_meter_top #(
  parameter int MAX_FRAME = frm_pkg::MAX_FRAME_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [frm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [frm_pkg::RMS_W-1:0]           rms,
  output logic [frm_pkg::COUNT_W-1:0]         sample_count,
  output logic                                overflow
);
  import frm_pkg::*;

  // count must hold MAX_FRAME itself; each square is at most 2^30
  localparam int CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int SUM_W  = 30 + CNT_W;
  localparam int ROOT_W = (SUM_W + 1) / 2;

  frm_cmd_t cmd;

  // sequencing and handshakes
  frm_ctrl #(
    .SUM_W  (SUM_W),
    .ROOT_W (ROOT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last      (last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // accumulator, divider, root unit and output register
  frm_dp #(
    .MAX_FRAME (MAX_FRAME),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .ROOT_W    (ROOT_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample       (sample),
    .rms          (rms),
    .sample_count (sample_count),
    .overflow     (overflow)
  );

endmodule

[tb/tb_frame_rms_meter_top.sv]
`timescale 1ns / 1ps

module tb_frame_rms_meter_top;

  import frm_pkg::*;

  // Frame length limit of the instance; the block is built with its default.
  localparam int FRAME_LIMIT = MAX_FRAME_DEF;
  // Settling wait after the final drain, before readings still due count as missing.
  localparam int SETTLE_CYCLES = 2 * SQUARE_W + 64;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       out_valid;
  logic                       out_ready;
  logic [RMS_W-1:0]           rms;
  logic [COUNT_W-1:0]         sample_count;
  logic                       overflow;

  // One frame reading as the block should report it.
  typedef struct packed {
    logic [RMS_W-1:0]   rms;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } frame_reading_t;

  // Readings predicted but not yet seen on the output port, oldest first.
  frame_reading_t readings_due[$];

  // Predictor copy of the frame accumulator.
  longint unsigned square_total;
  int              samples_held;
  bit              frame_overrun;

  // Run bookkeeping.
  int errors;
  int samples_sent;
  int frames_checked;
  int overrun_frames;
  bit gaps_on;

  frame_rms_meter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rms          (rms),
    .sample_count (sample_count),
    .overflow     (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor of the integer square root, built up one bit at a time from the top.
  // The mean never exceeds 2^30, so the root fits well within 21 bits.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Accumulate one transferred sample. Returns 1 with the reading filled in
  // when the sample closes a frame; the accumulator is then cleared.
  function automatic bit accumulate_sample(input logic signed [SAMPLE_W-1:0] s,
                                           input logic l,
                                           output frame_reading_t rd);
    longint          sq;
    longint unsigned mean;
    longint unsigned root;
    sq = longint'(s) * longint'(s);
    rd = '0;
    // A full frame drops further samples but remembers that it overran.
    if (samples_held < FRAME_LIMIT) begin
      square_total += longint'(unsigned'(sq));
      samples_held++;
    end else begin
      frame_overrun = 1'b1;
    end
    if (!l) return 1'b0;
    mean = square_total / longint'(unsigned'(samples_held));
    root = floor_root(mean);
    if (root > RMS_MAX) root = RMS_MAX;   // all -32768 gives root 32768
    rd.rms   = root[RMS_W-1:0];
    rd.count = (samples_held > COUNT_OUT_MAX) ? COUNT_OUT_MAX[COUNT_W-1:0]
                                              : samples_held[COUNT_W-1:0];
    rd.ovf   = frame_overrun;
    square_total  = 0;
    samples_held  = 0;
    frame_overrun = 1'b0;
    return 1'b1;
  endfunction

  // Offer one sample. Entered at a falling edge; returns at the falling edge
  // after the transfer with valid still high, so the caller either sends the
  // next sample straight away or drops valid itself.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
    frame_reading_t rd;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
    if (accumulate_sample(s, l, rd)) readings_due.push_back(rd);
    @(negedge clk);
  endtask

  // Half extremes and small values, the other half anywhere in the range.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'(int'($urandom_range(0, 16)) - 8);
      3:       return 16'(int'($urandom_range(0, 2)) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int i = 1; i <= len; i++) send_sample(pick_sample(), i == len);
  endtask

  // Hold the sender until every predicted reading has come out.
  task automatic drain_readings();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
  endtask

  // Result check: every output transfer against the oldest prediction.
  always @(posedge clk) begin : check_reading
    frame_reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        errors++;
        $display("%0t: reading with none expected: rms %0d count %0d overflow %0b",
                 $time, rms, sample_count, overflow);
      end else begin
        want = readings_due.pop_front();
        frames_checked++;
        if (want.ovf) overrun_frames++;
        if (rms !== want.rms) begin
          errors++;
          $display("%0t: rms expected %0d actual %0d", $time, want.rms, rms);
        end
        if (sample_count !== want.count) begin
          errors++;
          $display("%0t: sample_count expected %0d actual %0d",
                   $time, want.count, sample_count);
        end
        if (overflow !== want.ovf) begin
          errors++;
          $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, overflow);
        end
      end
    end
  end

  // Receiver back-pressure in random bursts while gaps are enabled.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Single-sample frames at the value extremes, then short mixed frames,
  // including frames where the root must saturate.
  task automatic test_value_extremes();
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd32768, 1'b1);   // root 32768, saturates
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd4096, 1'b1);     // 1.0 in Q4.12
    send_sample(-16'sd32768, 1'b0);   // multi-sample frame, all -32768
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(-16'sd32768, 1'b0);   // mixed signs and sizes
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b1);
    send_sample(16'sd0, 1'b0);        // tiny energy, mean floors to zero
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b1);
  endtask

  // A full-scale frame that fills to the limit and then overruns, then a
  // short frame to show the overrun flag and totals were cleared.
  task automatic test_frame_length_limit();
    for (int i = 1; i <= FRAME_LIMIT; i++) send_sample(-16'sd32768, 1'b0);
    for (int i = 0; i < 5; i++) send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);   // last sample itself is dropped
    send_sample(16'sd1000, 1'b1);
  endtask

  // After two frames the sender holds off until the block has nothing left to report.
  task automatic test_idle_between_frames();
    send_frame(3);
    send_frame(1);
    drain_readings();
    send_frame(2);
    send_frame(1);
  endtask

  // Random frames, mostly short with the odd long one.
  task automatic test_random_frames(input int n_samples);
    int target;
    target = samples_sent + n_samples;
    while (samples_sent < target) begin
      if ($urandom_range(0, 15) == 0) send_frame($urandom_range(60, 300));
      else send_frame($urandom_range(1, 20));
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate_tail();
    gaps_on = 1'b0;
    test_random_frames(100);
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    sample        = '0;
    last          = 1'b0;
    errors        = 0;
    samples_sent  = 0;
    frames_checked = 0;
    overrun_frames = 0;
    square_total  = 0;
    samples_held  = 0;
    frame_overrun = 1'b0;
    gaps_on       = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_value_extremes();
    test_frame_length_limit();
    test_idle_between_frames();
    test_random_frames(170);
    test_full_rate_tail();

    drain_readings();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (readings_due.size() != 0) begin
      errors++;
      $display("%0t: %0d readings never arrived", $time, readings_due.size());
    end

    $display("Sent %0d samples; checked %0d frame readings, %0d of them overrun,",
             samples_sent, frames_checked, overrun_frames);
    $display("with random gaps and stalls on both sides, then a full-rate tail.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
rtl/frm_pkg.sv
rtl/frm_ctrl.sv
rtl/frm_dp.sv
rtl/frame_rms_meter_top.sv
tb/tb_frame_rms_meter_top.sv
